// File: hdl/cdfs_pkg.sv
// Shared types and constants of the CDF table flow size sampler.
// No dependencies; imported by the table, divider and top level modules.
package cdfs_pkg;

   localparam int PROB_W = 17;   // unsigned Q1.16: one integer bit and 16 fraction bits
   localparam int SIZE_W = 32;
   localparam int IDX_W  = 6;
   localparam int CNT_W  = 7;

   localparam logic [SIZE_W-1:0] FLOOR_RESET = 32'd50;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic CSR_ENTRIES = 1'b0;
   localparam logic CSR_FLOOR   = 1'b1;

   typedef struct packed {
      logic [PROB_W-1:0] prob;
      logic [SIZE_W-1:0] size;
   } entry_type;

   typedef struct packed {
      logic        start;
      logic [PROB_W-1:0] num;
      logic [SIZE_W-1:0] mult;
      logic [PROB_W-1:0] den;
   } div_req_type;

endpackage

// File: hdl/cdfs_table.sv
// Single-port-write, single-port-read memory holding the (probability, size) pairs.
// Depends on cdfs_pkg for the entry type.
module cdfs_table
   import cdfs_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_data,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_data
);

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/cdfs_muldiv.sv
// Bit-serial multiply-divide: floor(num * mult / den) for num <= den, den > 0.
// One multiplier bit per cycle. Depends on cdfs_pkg.
module cdfs_muldiv
   import cdfs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  div_req_type       req,
   output logic              done,
   output logic [SIZE_W-1:0] quot
);

   localparam int CW = $clog2(SIZE_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [PROB_W-1:0] rem_ff, rem_in;
   logic [PROB_W-1:0] num_ff, num_in;
   logic [PROB_W-1:0] den_ff, den_in;
   logic [SIZE_W-1:0] mult_ff, mult_in;
   logic [SIZE_W-1:0] quot_ff, quot_in;

   logic [PROB_W:0] r2, r2b, r3, r4;
   logic            ge1, ge2;

   always_comb begin
      // Remainder stays below den, so doubling it and adding num fit in PROB_W+1 bits.
      r2  = {rem_ff, 1'b0};
      ge1 = r2 >= {1'b0, den_ff};
      r2b = ge1 ? r2 - {1'b0, den_ff} : r2;
      r3  = r2b + {1'b0, num_ff};
      ge2 = mult_ff[SIZE_W-1] && (r3 >= {1'b0, den_ff});
      if (mult_ff[SIZE_W-1]) begin
         r4 = ge2 ? r3 - {1'b0, den_ff} : r3;
      end else begin
         r4 = r2b;
      end

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      mult_in = mult_ff;
      quot_in = quot_ff;

      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quot_in = '0;
         num_in  = req.num;
         den_in  = req.den;
         mult_in = req.mult;
      end else if (busy_ff) begin
         rem_in  = r4[PROB_W-1:0];
         quot_in = {quot_ff[SIZE_W-2:0], 1'b0} + SIZE_W'(ge1) + SIZE_W'(ge2);
         mult_in = {mult_ff[SIZE_W-2:0], 1'b0};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CW'(SIZE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      mult_ff <= mult_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < den_ff)
      else $error("divider remainder not below divisor");

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      req.start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still busy");

endmodule

// File: hdl/cdf_table_flow_size_sampler.sv
// Flow size sampler by piecewise linear inverse-transform sampling over a stored CDF table.
//
// Channels: req_ carries one item, either a load (writes one probability/size pair into
// a table slot) or a sample (a uniform Q1.16 value). rsp_ returns one item per sample
// and none per load. csr_ writes entries_in_use (index 0) and floor_size (index 1); it
// is always ready. The user must write it only while the block is idle; the block
// does not enforce this. A load leaves req_ready high. A sample walks the table one
// entry a cycle from slot 0 through the table memory's single read port, then, when
// the matching entry has a nonzero probability step, runs a bit-serial multiply-divide
// for the interpolation. req_ready is high only between items; the next item can be
// accepted from the cycle in which the result appears.
// Reset clears entries_in_use to 0 and floor_size to 50; table contents are undefined
// until written. When the receiver stalls, the result waits in the output register
// while the next item is accepted and worked on; that item holds at its last step until
// the output register is free.
// Depends on cdfs_pkg, cdfs_table and cdfs_muldiv.
module cdf_table_flow_size_sampler
   import cdfs_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_operation,
   input  logic [IDX_W-1:0]  req_entry_index,
   input  logic [PROB_W-1:0] req_entry_probability,
   input  logic [SIZE_W-1:0] req_entry_size,
   input  logic [PROB_W-1:0] req_uniform_sample,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [SIZE_W-1:0] rsp_flow_size,
   output logic              rsp_floor_applied,
   output logic              rsp_entry_found,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [SIZE_W-1:0] csr_wdata
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_DIV,
      S_FINISH
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  entries_ff, entries_in;
   logic [SIZE_W-1:0] floor_ff, floor_in;
   logic [PROB_W-1:0] sample_ff, sample_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [PROB_W-1:0] prev_p_ff, prev_p_in;
   logic [SIZE_W-1:0] prev_s_ff, prev_s_in;
   logic              found_ff, found_in;
   logic [SIZE_W-1:0] result_ff, result_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SIZE_W-1:0] rsp_size_ff, rsp_size_in;
   logic              rsp_floor_ff, rsp_floor_in;
   logic              rsp_found_ff, rsp_found_in;

   logic              req_accept;
   logic [CW-1:0]     count_eff;
   logic [CW-1:0]     idx_next;
   logic              wr_en;
   entry_type         wr_data;
   logic [AW-1:0]     rd_addr;
   entry_type         rd_data;
   div_req_type       div_req;
   logic              div_done;
   logic [SIZE_W-1:0] div_quot;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   // Count beyond the table saturates to the table depth.
   assign count_eff = (32'(entries_ff) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                           : CW'(entries_ff);
   assign idx_next  = idx_ff + 1'b1;

   assign wr_en        = req_accept && (req_operation == OP_LOAD)
                         && (32'(req_entry_index) < 32'(TABLE_DEPTH));
   assign wr_data.prob = req_entry_probability;
   assign wr_data.size = req_entry_size;
   // Slot 0 is read while idle so its data is ready in the first walk cycle.
   assign rd_addr      = (state_ff == S_WALK) ? idx_next[AW-1:0] : '0;

   cdfs_table #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_entry_index)),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cdfs_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      div_req.num  = sample_ff - prev_p_ff;
      div_req.den  = rd_data.prob - prev_p_ff;
      // Decreasing sizes clamp the size step to zero.
      div_req.mult = (rd_data.size > prev_s_ff) ? rd_data.size - prev_s_ff : '0;
      div_req.start = 1'b0;

      entries_in = entries_ff;
      floor_in   = floor_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ENTRIES: entries_in = csr_wdata[CNT_W-1:0];
            CSR_FLOOR:   floor_in   = csr_wdata;
            default:     entries_in = entries_ff;
         endcase
      end

      state_in     = state_ff;
      sample_in    = sample_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      prev_p_in    = prev_p_ff;
      prev_s_in    = prev_s_ff;
      found_in     = found_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_size_in  = rsp_size_ff;
      rsp_floor_in = rsp_floor_ff;
      rsp_found_in = rsp_found_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept && (req_operation == OP_SAMPLE)) begin
               sample_in = req_uniform_sample;
               count_in  = count_eff;
               idx_in    = '0;
               prev_p_in = '0;
               prev_s_in = '0;
               found_in  = 1'b0;
               result_in = '0;
               state_in  = (count_eff == '0) ? S_FINISH : S_WALK;
            end
         end
         S_WALK: begin
            if (sample_ff <= rd_data.prob) begin
               found_in = 1'b1;
               if (rd_data.prob == prev_p_ff) begin
                  // Zero probability step: the entry's own size.
                  result_in = rd_data.size;
                  state_in  = S_FINISH;
               end else begin
                  div_req.start = 1'b1;
                  state_in      = S_DIV;
               end
            end else begin
               prev_p_in = rd_data.prob;
               prev_s_in = rd_data.size;
               idx_in    = idx_next;
               if (idx_next == count_ff) begin
                  state_in = S_FINISH;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               result_in = prev_s_ff + div_quot;
               state_in  = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               if (!found_ff || (result_ff == '0)) begin
                  rsp_size_in  = floor_ff;
                  rsp_floor_in = 1'b1;
               end else begin
                  rsp_size_in  = result_ff;
                  rsp_floor_in = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         entries_ff   <= '0;
         floor_ff     <= FLOOR_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         entries_ff   <= entries_in;
         floor_ff     <= floor_in;
      end
      sample_ff    <= sample_in;
      count_ff     <= count_in;
      idx_ff       <= idx_in;
      prev_p_ff    <= prev_p_in;
      prev_s_ff    <= prev_s_in;
      found_ff     <= found_in;
      result_ff    <= result_in;
      rsp_size_ff  <= rsp_size_in;
      rsp_floor_ff <= rsp_floor_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_flow_size     = rsp_size_ff;
   assign rsp_floor_applied = rsp_floor_ff;
   assign rsp_entry_found   = rsp_found_ff;

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (idx_ff < count_ff))
      else $error("table walk past the entries in use");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider result outside the divide step");

   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_operation == OP_LOAD)) |=> (state_ff == S_IDLE))
      else $error("load item started a sample");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FINISH))
      else $error("result item raised outside the finish step");

endmodule

// File: verif/tb_cdf_table_flow_size_sampler.sv
// Self-checking testbench for the CDF table flow size sampler.
// Drives load and sample items plus register writes, and predicts each drawn size.
// Depends on cdfs_pkg and cdf_table_flow_size_sampler.
module tb_cdf_table_flow_size_sampler
   import cdfs_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_SLOTS    = 64;
   localparam int PROB_ONE       = 65536;
   localparam int RESET_CYCLES   = 12;
   localparam int LOAD_SETTLE    = 4;
   localparam int END_QUIET      = 200;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int NUM_PHASES     = 8;
   localparam int PHASE_ITEMS    = 150;
   localparam int HOLD_AT        = 60;
   localparam int HOLD_CYCLES    = 1200;

   typedef struct packed {
      logic [SIZE_W-1:0] flow_size;
      logic              floor_applied;
      logic              entry_found;
   } draw_type;

   typedef enum logic [1:0] {ROW_LOAD, ROW_SAMPLE, ROW_SET_COUNT, ROW_SET_FLOOR} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [IDX_W-1:0]  index;
      logic [PROB_W-1:0] value;   // entry probability or uniform sample
      logic [SIZE_W-1:0] data;    // entry size or register value
      logic              typed;
      draw_type          want;
   } script_row_type;

   localparam draw_type NO_DRAW = '0;
   localparam int NUM_ROWS = 24;

   // Table 0..3 is (0,7) (16384,1000) (32768,500) (65536,max): a zero first step,
   // a falling size and a full-scale top entry. Slot 63 takes the largest index.
   localparam script_row_type SCRIPT [NUM_ROWS] = '{
      '{ROW_SAMPLE,    6'd0,  17'd0,      32'd0,          1'b1, '{FLOOR_RESET, 1'b1, 1'b0}},
      '{ROW_SAMPLE,    6'd0,  17'd65536,  32'd0,          1'b1, '{FLOOR_RESET, 1'b1, 1'b0}},
      '{ROW_SAMPLE,    6'd0,  17'd131071, 32'd0,          1'b1, '{FLOOR_RESET, 1'b1, 1'b0}},
      '{ROW_LOAD,      6'd0,  17'd0,      32'd7,          1'b0, NO_DRAW},
      '{ROW_LOAD,      6'd1,  17'd16384,  32'd1000,       1'b0, NO_DRAW},
      '{ROW_LOAD,      6'd2,  17'd32768,  32'd500,        1'b0, NO_DRAW},
      '{ROW_LOAD,      6'd3,  17'd65536,  32'hFFFF_FFFF,  1'b0, NO_DRAW},
      '{ROW_LOAD,      6'd63, 17'd65535,  32'h5555_AAAA,  1'b0, NO_DRAW},
      '{ROW_SET_COUNT, 6'd0,  17'd0,      32'd4,          1'b0, NO_DRAW},
      '{ROW_SAMPLE,    6'd0,  17'd0,      32'd0,          1'b1, '{32'd7, 1'b0, 1'b1}},
      '{ROW_SAMPLE,    6'd0,  17'd1,      32'd0,          1'b0, NO_DRAW},
      '{ROW_SAMPLE,    6'd0,  17'd16384,  32'd0,          1'b1, '{32'd1000, 1'b0, 1'b1}},
      '{ROW_SAMPLE,    6'd0,  17'd20000,  32'd0,          1'b0, NO_DRAW},
      '{ROW_SAMPLE,    6'd0,  17'd65536,  32'd0,          1'b1, '{32'hFFFF_FFFF, 1'b0, 1'b1}},
      '{ROW_SAMPLE,    6'd0,  17'd50000,  32'd0,          1'b0, NO_DRAW},
      '{ROW_SAMPLE,    6'd0,  17'd65537,  32'd0,          1'b1, '{FLOOR_RESET, 1'b1, 1'b0}},
      '{ROW_SET_FLOOR, 6'd0,  17'd0,      32'd0,          1'b0, NO_DRAW},
      '{ROW_SAMPLE,    6'd0,  17'd131071, 32'd0,          1'b1, '{32'd0, 1'b1, 1'b0}},
      '{ROW_SET_FLOOR, 6'd0,  17'd0,      32'hFFFF_FFFF,  1'b0, NO_DRAW},
      '{ROW_LOAD,      6'd0,  17'd100,    32'd0,          1'b0, NO_DRAW},
      '{ROW_SAMPLE,    6'd0,  17'd50,     32'd0,          1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b1}},
      '{ROW_SAMPLE,    6'd0,  17'd100,    32'd0,          1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b1}},
      '{ROW_SET_COUNT, 6'd0,  17'd0,      32'd0,          1'b0, NO_DRAW},
      '{ROW_SAMPLE,    6'd0,  17'd5,      32'd0,          1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0}}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_operation = OP_LOAD;
   logic [IDX_W-1:0]  req_entry_index = '0;
   logic [PROB_W-1:0] req_entry_probability = '0;
   logic [SIZE_W-1:0] req_entry_size = '0;
   logic [PROB_W-1:0] req_uniform_sample = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [SIZE_W-1:0] rsp_flow_size;
   logic              rsp_floor_applied;
   logic              rsp_entry_found;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic              csr_index = CSR_ENTRIES;
   logic [SIZE_W-1:0] csr_wdata = '0;

   // Mirror of the table and the registers, updated as items and writes are accepted.
   logic [PROB_W-1:0] cdf_prob [TABLE_SLOTS];
   logic [SIZE_W-1:0] cdf_size [TABLE_SLOTS];
   logic [CNT_W-1:0]  entries_cfg = '0;
   logic [SIZE_W-1:0] floor_cfg = FLOOR_RESET;

   draw_type pending_draws [$];
   int       mismatches = 0;
   int       draws_seen = 0;
   int       hold_left = 0;
   int       quiet_cycles = 0;
   bit       steady_run = 1'b0;

   cdf_table_flow_size_sampler DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_operation         (req_operation),
      .req_entry_index       (req_entry_index),
      .req_entry_probability (req_entry_probability),
      .req_entry_size        (req_entry_size),
      .req_uniform_sample    (req_uniform_sample),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_flow_size         (rsp_flow_size),
      .rsp_floor_applied     (rsp_floor_applied),
      .rsp_entry_found       (rsp_entry_found),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always #4 clock = ~clock;

   // Inverse-transform draw: first entry at or above the sample, interpolated from the
   // entry before it (or from the origin), with the floor size for zero or no match.
   function automatic draw_type predict_draw(input logic [PROB_W-1:0] u);
      draw_type          d;
      int                n;
      logic [63:0]       lo_p, lo_s, diff;
      logic [SIZE_W-1:0] sz;
      d = '0;
      sz = '0;
      n = (entries_cfg > TABLE_SLOTS) ? TABLE_SLOTS : int'(entries_cfg);
      for (int i = 0; i < n && !d.entry_found; i++) begin
         if (u <= cdf_prob[i]) begin
            d.entry_found = 1'b1;
            lo_p = '0;
            lo_s = '0;
            if (i > 0) begin
               lo_p = 64'(cdf_prob[i-1]);
               lo_s = 64'(cdf_size[i-1]);
            end
            if (64'(cdf_prob[i]) == lo_p) begin
               sz = cdf_size[i];
            end else begin
               diff = (64'(cdf_size[i]) > lo_s) ? 64'(cdf_size[i]) - lo_s : 64'd0;
               sz = SIZE_W'(lo_s + ((64'(u) - lo_p) * diff) / (64'(cdf_prob[i]) - lo_p));
            end
         end
      end
      d.floor_applied = !d.entry_found || sz == 0;
      d.flow_size = d.floor_applied ? floor_cfg : sz;
      return d;
   endfunction

   function automatic void queue_draw(input draw_type d);
      pending_draws = {pending_draws, d};
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_run || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(30, 200);
   endfunction

   function automatic logic [PROB_W-1:0] pick_sample();
      int                r;
      logic [PROB_W-1:0] p;
      r = $urandom_range(0, 99);
      p = cdf_prob[$urandom_range(0, TABLE_SLOTS-1)];
      if (r < 50) return PROB_W'($urandom_range(0, PROB_ONE));
      if (r < 65) return p;
      if (r < 75) return p + 1'b1;
      if (r < 80) return p - 1'b1;
      if (r < 85) return r[0] ? PROB_W'(PROB_ONE) : '0;
      return PROB_W'($urandom_range(PROB_ONE + 1, (1 << PROB_W) - 1));
   endfunction

   task automatic offer_item(input logic op, input logic [IDX_W-1:0] idx,
         input logic [PROB_W-1:0] prob, input logic [SIZE_W-1:0] sz,
         input logic [PROB_W-1:0] u, input logic typed, input draw_type want);
      int gap;
      req_valid <= 1'b1;
      req_operation <= op;
      req_entry_index <= idx;
      req_entry_probability <= prob;
      req_entry_size <= sz;
      req_uniform_sample <= u;
      do @(posedge clock); while (!req_ready);
      if (op == OP_LOAD) begin
         cdf_prob[idx] = prob;
         cdf_size[idx] = sz;
      end else if (typed) begin
         queue_draw(want);
      end else begin
         queue_draw(predict_draw(u));
      end
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Registers change only with the block idle: no draw outstanding and any load done.
   task automatic drain_block();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_draws.size() != 0);
      repeat (LOAD_SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [SIZE_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_ENTRIES) entries_cfg = data[CNT_W-1:0];
      else floor_cfg = data;
      @(posedge clock);
   endtask

   task automatic run_row(input script_row_type row);
      case (row.kind)
         ROW_LOAD: begin
            offer_item(OP_LOAD, row.index, row.value, row.data, PROB_W'($urandom), 1'b0,
                       NO_DRAW);
         end
         ROW_SAMPLE: begin
            offer_item(OP_SAMPLE, IDX_W'($urandom), PROB_W'($urandom), $urandom, row.value,
                       row.typed, row.want);
         end
         ROW_SET_COUNT: begin
            drain_block();
            write_reg(CSR_ENTRIES, row.data);
         end
         default: begin
            drain_block();
            write_reg(CSR_FLOOR, row.data);
         end
      endcase
   endtask

   // Writes a fresh nondecreasing CDF into every slot. Sizes follow one of three shapes:
   // slowly rising with occasional drops, fully random, or crowded near the top.
   task automatic refill_table();
      int                shape, tmp;
      logic [PROB_W-1:0] p;
      logic [SIZE_W-1:0] s;
      shape = $urandom_range(0, 2);
      p = ($urandom_range(0, 3) == 0) ? '0 : PROB_W'($urandom_range(0, 2048));
      s = $urandom_range(0, 100);
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         if (i > 0 && $urandom_range(0, 19) != 0) begin
            tmp = p + $urandom_range(0, 2100);
            p = (tmp > PROB_ONE) ? PROB_W'(PROB_ONE) : PROB_W'(tmp);
         end
         if (i == TABLE_SLOTS - 1 && $urandom_range(0, 1)) p = PROB_W'(PROB_ONE);
         case (shape)
            0: s = ($urandom_range(0, 9) == 0) ? s >> 1 : s + $urandom_range(0, 100000);
            1: s = $urandom;
            default: s = ($urandom_range(0, 63) == 0) ? 0 : ~$urandom_range(0, 1 << 20);
         endcase
         offer_item(OP_LOAD, IDX_W'(i), p, s, PROB_W'($urandom), 1'b0, NO_DRAW);
      end
   endtask

   function automatic logic [SIZE_W-1:0] pick_count(input int ph);
      case (ph)
         0: return TABLE_SLOTS;
         1: return (1 << CNT_W) - 1;
         2: return 1;
         3: return 2;
         default: begin
            if ($urandom_range(0, 9) < 7) return $urandom_range(1, TABLE_SLOTS);
            return $urandom_range(TABLE_SLOTS + 1, (1 << CNT_W) - 1);
         end
      endcase
   endfunction

   function automatic logic [SIZE_W-1:0] pick_floor();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) return '0;
      if (r < 50) return '1;
      return $urandom;
   endfunction

   task automatic random_item();
      if ($urandom_range(0, 99) < 15) begin
         offer_item(OP_LOAD, IDX_W'($urandom_range(0, TABLE_SLOTS-1)),
                    PROB_W'($urandom_range(0, PROB_ONE)), $urandom, PROB_W'($urandom),
                    1'b0, NO_DRAW);
      end else begin
         offer_item(OP_SAMPLE, IDX_W'($urandom), PROB_W'($urandom), $urandom, pick_sample(),
                    1'b0, NO_DRAW);
      end
   endtask

   task automatic check_draw();
      draw_type want;
      if (pending_draws.size() == 0) begin
         $error("flow_size: no item expected, got %0d", rsp_flow_size);
         mismatches++;
      end else begin
         want = pending_draws.pop_front();
         if (rsp_flow_size !== want.flow_size) begin
            $error("flow_size: expected %0d, got %0d", want.flow_size, rsp_flow_size);
            mismatches++;
         end
         if (rsp_floor_applied !== want.floor_applied) begin
            $error("floor_applied: expected %0d, got %0d", want.floor_applied,
                   rsp_floor_applied);
            mismatches++;
         end
         if (rsp_entry_found !== want.entry_found) begin
            $error("entry_found: expected %0d, got %0d", want.entry_found, rsp_entry_found);
            mismatches++;
         end
      end
   endtask

   // Receiver: random stalls outside steady phases, and one long hold-off, in any phase, that
   // lets the block fill up while the sender keeps offering items.
   always @(posedge clock) begin : receiver
      int r;
      if (!reset && rsp_valid && rsp_ready) begin
         check_draw();
         draws_seen++;
         if (draws_seen == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (steady_run) begin
         rsp_ready <= 1'b1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 65) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            hold_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(20, 120);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("cdf_table_flow_size_sampler: mismatch");
         $finish;
      end
   end

   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int k = 0; k < NUM_ROWS; k++) run_row(SCRIPT[k]);
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         steady_run = (ph == 0 || ph == 4);
         // The first refill covers every slot, so no later draw reads an empty slot.
         if (ph == 0 || $urandom_range(0, 1)) refill_table();
         drain_block();
         write_reg(CSR_ENTRIES, pick_count(ph));
         write_reg(CSR_FLOOR, pick_floor());
         repeat (PHASE_ITEMS) random_item();
      end
      steady_run = 1'b0;
      drain_block();
      repeat (END_QUIET) @(posedge clock);
      if (mismatches == 0)
         $display("cdf_table_flow_size_sampler: match");
      else
         $display("cdf_table_flow_size_sampler: mismatch");
      $finish;
   end

endmodule
